### rtl/core/oarb_pkg.sv
// Shared types, constants and a helper function of the overlap-add ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package oarb_pkg;

   localparam int CMD_W       = 2;
   localparam int OFFSET_W    = 12;
   localparam int SAMPLE_W    = 24;
   localparam int AMOUNT_W    = 13;
   localparam int COUNT_W     = 13;
   localparam int PTR_W       = 12;
   localparam int SIZE_LOG2_W = 4;

   localparam int                     SIZE_LOG2_HI    = 12;
   localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_LO    = 4'd1;
   localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 4'd12;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_LOG2 = 1'b0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_MIX     = 2'd0,
      CMD_PASTE   = 2'd1,
      CMD_READ    = 2'd2,
      CMD_ADVANCE = 2'd3
   } cmd_type;

   // One memory operation handed from the front end to the back end.
   typedef struct packed {
      cmd_type                    cmd;
      logic [PTR_W-1:0]           addr;       // entry index, or first entry to zero
      logic signed [SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0]         count;      // entries to zero for an advance
      logic [COUNT_W-1:0]         remaining;
      logic                       has_data;
   } op_type;

   typedef struct packed {
      logic [PTR_W-1:0] mask;
      logic             clear_req;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Largest ring log2 that fits in the given storage depth.
   function automatic int ring_log2_max(input int depth);
      int lg;
      lg = 1;
      for (int i = 1; i <= SIZE_LOG2_HI; i++) begin
         if ((64'd1 << i) <= 64'(depth)) begin
            lg = i;
         end
      end
      return lg;
   endfunction

endpackage

`default_nettype wire

### rtl/core/oarb_channels.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface oarb_req_if;
   import oarb_pkg::*;

   logic                       valid;
   logic                       ready;
   cmd_type                    cmd;
   logic [OFFSET_W-1:0]        offset;
   logic signed [SAMPLE_W-1:0] sample;
   logic [AMOUNT_W-1:0]        amount;

   modport source (output valid, cmd, offset, sample, amount, input ready);
   modport sink   (input valid, cmd, offset, sample, amount, output ready);
endinterface

interface oarb_rsp_if;
   import oarb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] read_sample;
   logic [COUNT_W-1:0]         remaining;
   logic                       has_data;

   modport source (output valid, read_sample, remaining, has_data, input ready);
   modport sink   (input valid, read_sample, remaining, has_data, output ready);
endinterface

`default_nettype wire

### rtl/core/overlap_add_ring_buffer_unit.sv
// Top level of the overlap-add ring buffer: front end, operation queue, back end.
//
//   Channel   Direction  Handshake               Word
//   req_ch    in         valid/ready             cmd, offset, sample, amount
//   rsp_ch    out        valid/ready             read_sample, remaining, has_data
//   csr_*     in/out     APB, pready always 1    size_log2 at byte address 0
//
// The front end takes up to one command word per cycle into a two-entry queue. The
// back end, which owns the single write / single read port of the sample store, sets
// the pace: paste finishes in the idle state, read and mix pass through one more state
// (registered read, then result or write-back), advance zeroes n = min(amount, ring
// size) entries in turn. After reset and after every size_log2 write the back end
// sweeps the store clear, one entry per cycle over all 2**min(12, floor(log2(DEPTH)))
// entries (4096 at the default), with req_ch.ready low; register writes are still taken.
// A stalled result stays in the output register while the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none

module overlap_add_ring_buffer_unit #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   oarb_req_if.sink                             req_ch,
   oarb_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [oarb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [oarb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [oarb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import oarb_pkg::*;

   // Operations travel through the queue in command order, so the back end
   // never needs the pointer or the pending count: the front end resolves both
   // when it takes the word and stores the result fields with the operation.
   op_type          push_op;
   logic            push_valid;
   logic            push_ready;
   op_type          pop_op;
   logic            pop_valid;
   logic            pop;
   cfg_type         cfg;
   back_status_type status;

   oarb_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .push_op     (push_op),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .status      (status),
      .cfg         (cfg)
   );

   oarb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_op     (pop_op),
      .pop_valid  (pop_valid),
      .pop        (pop)
   );

   // The back end performs every store access, including the clearing sweep
   // that follows reset and each size register write.
   oarb_back #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_op    (pop_op),
      .q_valid (pop_valid),
      .q_pop   (pop),
      .status  (status),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

### rtl/core/oarb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module oarb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/oarb_queue.sv
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module oarb_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire oarb_pkg::op_type push_op,
   input  wire logic            push_valid,
   output      logic            push_ready,
   output      oarb_pkg::op_type pop_op,
   output      logic            pop_valid,
   input  wire logic            pop
);
   import oarb_pkg::*;

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

### rtl/core/oarb_front.sv
// Front end: takes command words, keeps pointer, pending count and size register.
`timescale 1ns / 1ps
`default_nettype none

module oarb_front #(
   parameter int DEPTH = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   oarb_req_if.sink                                 req_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [oarb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [oarb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [oarb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready,
   output      oarb_pkg::op_type                    push_op,
   output      logic                                push_valid,
   input  wire logic                                push_ready,
   input  wire oarb_pkg::back_status_type           status,
   output      oarb_pkg::cfg_type                   cfg
);
   import oarb_pkg::*;

   localparam logic [SIZE_LOG2_W-1:0] LG_MAX = SIZE_LOG2_W'(ring_log2_max(DEPTH));

   logic [SIZE_LOG2_W-1:0] size_log2_ff, size_log2_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [COUNT_W-1:0]     pending_ff, pending_in;
   logic                   clear_req_ff, clear_req_in;

   logic [SIZE_LOG2_W-1:0] lg_eff;
   logic [PTR_W-1:0]       mask;
   logic [COUNT_W-1:0]     ring_size;
   logic [PTR_W-1:0]       off_m;
   logic [PTR_W-1:0]       idx;
   logic [COUNT_W-1:0]     off_inc;
   logic [COUNT_W-1:0]     zero_count;
   logic                   csr_hit;
   logic                   csr_wr;
   logic                   accept;

   always_comb begin
      if (size_log2_ff < SIZE_LOG2_LO) begin
         lg_eff = SIZE_LOG2_LO;
      end else if (size_log2_ff > LG_MAX) begin
         lg_eff = LG_MAX;
      end else begin
         lg_eff = size_log2_ff;
      end
   end

   assign mask      = PTR_W'((COUNT_W'(1) << lg_eff) - COUNT_W'(1));
   assign ring_size = {1'b0, mask} + COUNT_W'(1);

   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_SIZE_LOG2;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(size_log2_ff) : '0;

   // No words are taken while the store is being swept clear.
   assign req_ch.ready = push_ready && !status.clearing && !clear_req_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_valid   = accept;

   assign off_m      = req_ch.offset & mask;
   assign idx        = (ptr_ff + off_m) & mask;
   assign off_inc    = {1'b0, off_m} + COUNT_W'(1);
   assign zero_count = (req_ch.amount < ring_size) ? req_ch.amount : ring_size;

   always_comb begin
      ptr_in       = ptr_ff;
      pending_in   = pending_ff;
      size_log2_in = size_log2_ff;
      clear_req_in = 1'b0;
      if (accept) begin
         case (req_ch.cmd)
            CMD_MIX, CMD_PASTE: begin
               if (pending_ff < off_inc) begin
                  pending_in = off_inc;
               end
            end
            CMD_ADVANCE: begin
               ptr_in     = (ptr_ff + req_ch.amount[PTR_W-1:0]) & mask;
               pending_in = (pending_ff > req_ch.amount) ? pending_ff - req_ch.amount : '0;
            end
            default: begin
               pending_in = pending_ff;
            end
         endcase
      end
      if (csr_wr) begin
         size_log2_in = csr_pwdata[SIZE_LOG2_W-1:0];
         ptr_in       = '0;
         clear_req_in = 1'b1;
      end
   end

   always_comb begin
      push_op.cmd       = req_ch.cmd;
      push_op.addr      = (req_ch.cmd == CMD_ADVANCE) ? ptr_ff : idx;
      push_op.sample    = req_ch.sample;
      push_op.count     = zero_count;
      push_op.remaining = pending_in;
      push_op.has_data  = pending_in != '0;
   end

   assign cfg.mask      = mask;
   assign cfg.clear_req = clear_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
         ptr_ff       <= '0;
         pending_ff   <= '0;
         clear_req_ff <= 1'b0;
      end else begin
         size_log2_ff <= size_log2_in;
         ptr_ff       <= ptr_in;
         pending_ff   <= pending_in;
         clear_req_ff <= clear_req_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/oarb_back.sv
// Back end: runs queued operations against the sample store and drives results.
`timescale 1ns / 1ps
`default_nettype none

module oarb_back #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire oarb_pkg::cfg_type          cfg,
   input  wire oarb_pkg::op_type           q_op,
   input  wire logic                       q_valid,
   output      logic                       q_pop,
   output      oarb_pkg::back_status_type  status,
   oarb_rsp_if.source                      rsp_ch
);
   import oarb_pkg::*;

   localparam int MEM_DEPTH = 1 << ring_log2_max(DEPTH);
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int WW        = ((SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W) + 1;

   localparam logic signed [WW-1:0] SMP_MAX =
      {{(WW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [WW-1:0] SMP_MIN = ~SMP_MAX;
   localparam logic [AW-1:0]        CLR_LAST = AW'(MEM_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_MIX,
      S_ZERO
   } state_type;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic [COUNT_W-1:0]         cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [COUNT_W-1:0]         rsp_remaining_ff, rsp_remaining_in;
   logic                       rsp_has_data_ff, rsp_has_data_in;

   logic                        mem_we, mem_re;
   logic [AW-1:0]               mem_waddr, mem_raddr;
   logic [SAMPLE_BITS-1:0]      mem_wdata;
   logic signed [SAMPLE_BITS-1:0] mem_rdata;

   op_type                     res_op;
   logic                       out_free;
   logic                       deliver;
   logic signed [SAMPLE_W-1:0] deliver_sample;
   logic [PTR_W-1:0]           zaddr;
   logic signed [WW-1:0]       smp_ext, smp_sat;
   logic signed [WW-1:0]       rd_ext, sum, sum_sat;

   oarb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign res_op   = (state_ff == S_IDLE) ? q_op : op_ff;
   assign zaddr    = (op_ff.addr + cnt_ff[PTR_W-1:0]) & cfg.mask;

   // Input sample clamped to the stored sample range.
   always_comb begin
      smp_ext = WW'(res_op.sample);
      if (smp_ext > SMP_MAX) begin
         smp_sat = SMP_MAX;
      end else if (smp_ext < SMP_MIN) begin
         smp_sat = SMP_MIN;
      end else begin
         smp_sat = smp_ext;
      end
   end

   // Saturating mix of the stored entry and the incoming sample.
   always_comb begin
      rd_ext = WW'(mem_rdata);
      sum    = rd_ext + smp_sat;
      if (sum > SMP_MAX) begin
         sum_sat = SMP_MAX;
      end else if (sum < SMP_MIN) begin
         sum_sat = SMP_MIN;
      end else begin
         sum_sat = sum;
      end
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in    = rsp_sample_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rsp_has_data_in  = rsp_has_data_ff;
      deliver          = 1'b0;
      deliver_sample   = '0;
      mem_we           = 1'b0;
      mem_waddr        = zaddr[AW-1:0];
      mem_wdata        = '0;
      mem_re           = 1'b0;
      mem_raddr        = q_op.addr[AW-1:0];
      q_pop            = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            if (cnt_ff[AW-1:0] == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               op_in = q_op;
               case (q_op.cmd)
                  CMD_MIX: begin
                     mem_re   = 1'b1;
                     state_in = S_MIX;
                  end
                  CMD_PASTE: begin
                     mem_we    = 1'b1;
                     mem_waddr = q_op.addr[AW-1:0];
                     mem_wdata = smp_sat[SAMPLE_BITS-1:0];
                     deliver   = 1'b1;
                  end
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     state_in = S_READ;
                  end
                  default: begin
                     if (q_op.count != '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = q_op.addr[AW-1:0];
                     end
                     if (q_op.count <= COUNT_W'(1)) begin
                        deliver = 1'b1;
                     end else begin
                        cnt_in   = COUNT_W'(1);
                        state_in = S_ZERO;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               deliver        = 1'b1;
               deliver_sample = rd_ext[SAMPLE_W-1:0];
               state_in       = S_IDLE;
            end
         end
         S_MIX: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = op_ff.addr[AW-1:0];
               mem_wdata = sum_sat[SAMPLE_BITS-1:0];
               deliver   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_ZERO: begin
            if (cnt_ff != op_ff.count) begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (((COUNT_W'(cnt_ff + 1'b1) == op_ff.count) || (cnt_ff == op_ff.count))
                && out_free) begin
               deliver  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (deliver) begin
         rsp_valid_in     = 1'b1;
         rsp_sample_in    = deliver_sample;
         rsp_remaining_in = res_op.remaining;
         rsp_has_data_in  = res_op.has_data;
      end

      if (cfg.clear_req) begin
         state_in = S_CLEAR;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      rsp_sample_ff    <= rsp_sample_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_has_data_ff  <= rsp_has_data_in;
   end

   assign status.clearing = state_ff == S_CLEAR;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_sample = rsp_sample_ff;
   assign rsp_ch.remaining   = rsp_remaining_ff;
   assign rsp_ch.has_data    = rsp_has_data_ff;

endmodule

`default_nettype wire

### bench/ring_buffer_checker.sv
// Checker for the overlap-add ring buffer: watches both channels and the register writes, predicts and compares words.
`timescale 1ns / 1ps

module ring_buffer_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   oarb_req_if                                  req_mon,
   oarb_rsp_if                                  rsp_mon,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [oarb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [oarb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                            csr_pready,
   output int                                   mismatches,
   output int                                   results_due
);
   import oarb_pkg::*;

   localparam int RING_DEPTH = 4096;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] read_sample;
      logic [COUNT_W-1:0]         remaining;
      logic                       has_data;
   } ring_result_type;

   // Own copy of the block state and its one register.
   logic signed [SAMPLE_W-1:0] ring [0:RING_DEPTH-1];
   int                         read_ptr;
   int                         pending;
   logic [SIZE_LOG2_W-1:0]     size_sel;

   ring_result_type expected_words [$];

   task automatic clear_ring();
      for (int i = 0; i < RING_DEPTH; i++) begin
         ring[i] = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Applies one command to the state copy and returns the result word it causes.
   task automatic apply_command(input cmd_type cmd, input logic [OFFSET_W-1:0] offset,
                                input logic signed [SAMPLE_W-1:0] sample,
                                input logic [AMOUNT_W-1:0] amount,
                                output ring_result_type res);
      int lg;
      int ring_len;
      int mask;
      int off;
      int idx;
      int sum;
      int smp;
      int n;
      int amt;
      int max_v;
      int min_v;
      lg = int'(size_sel);
      if (lg < 1) lg = 1;
      if (lg > SIZE_LOG2_HI) lg = SIZE_LOG2_HI;
      ring_len = 1 << lg;
      mask = ring_len - 1;
      off = int'(offset) & mask;
      idx = (read_ptr + off) & mask;
      smp = int'(sample);
      amt = int'(amount);
      max_v = (1 << (SAMPLE_W - 1)) - 1;
      min_v = -max_v - 1;
      res = '0;
      case (cmd)
         CMD_MIX: begin
            sum = int'(ring[idx]);
            sum = sum + smp;
            if (sum > max_v) sum = max_v;
            if (sum < min_v) sum = min_v;
            ring[idx] = sum[SAMPLE_W-1:0];
            if (pending < off + 1) pending = off + 1;
         end
         CMD_PASTE: begin
            ring[idx] = sample;
            if (pending < off + 1) pending = off + 1;
         end
         CMD_READ: begin
            res.read_sample = ring[idx];
         end
         CMD_ADVANCE: begin
            // Anything from the ring size upward clears the whole ring.
            n = (amt < ring_len) ? amt : ring_len;
            for (int i = 0; i < n; i++) begin
               ring[(read_ptr + i) & mask] = '0;
            end
            read_ptr = (read_ptr + (amt & mask)) & mask;
            pending = (pending > amt) ? pending - amt : 0;
         end
         default: ;
      endcase
      res.remaining = pending[COUNT_W-1:0];
      res.has_data = (pending > 0);
   endtask

   always @(posedge clock) begin
      ring_result_type want;
      ring_result_type got;
      if (reset) begin
         clear_ring();
         read_ptr = 0;
         pending = 0;
         size_sel = SIZE_LOG2_RESET;
         expected_words.delete();
      end else begin
         // A size write clears the store and the pointer but keeps the pending count.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_SIZE_LOG2) begin
            size_sel = csr_pwdata[SIZE_LOG2_W-1:0];
            clear_ring();
            read_ptr = 0;
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_command(req_mon.cmd, req_mon.offset, req_mon.sample, req_mon.amount, want);
            expected_words.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_sample = rsp_mon.read_sample;
            got.remaining = rsp_mon.remaining;
            got.has_data = rsp_mon.has_data;
            if (expected_words.size() == 0) begin
               report_mismatch("result word with none expected, remaining",
                               int'(got.remaining), -1);
            end else begin
               want = expected_words.pop_front();
               if (got.read_sample !== want.read_sample)
                  report_mismatch("read_sample", int'(got.read_sample),
                                  int'(want.read_sample));
               if (got.remaining !== want.remaining)
                  report_mismatch("remaining", int'(got.remaining), int'(want.remaining));
               if (got.has_data !== want.has_data)
                  report_mismatch("has_data", int'(got.has_data), int'(want.has_data));
            end
         end
      end
      results_due = expected_words.size();
   end

endmodule

### bench/testbench.sv
// Top of the overlap-add ring buffer bench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
   import oarb_pkg::*;

   // Longest stretch without any word moving: it must outlast a clearing sweep, a
   // full-ring advance and the long result hold-off.
   localparam int QUIET_LIMIT = 25000;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 220;
   localparam int PHASE_WORDS = 95;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int results_due;
   int words_sent;

   oarb_req_if req_ch ();
   oarb_rsp_if rsp_ch ();

   overlap_add_ring_buffer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ring_buffer_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one command word. It is entered just after a falling edge and returns
   // just after the falling edge that follows the acceptance, with valid still high
   // so that a back-to-back word can follow without a bubble.
   task automatic send_word(input cmd_type cmd, input logic [OFFSET_W-1:0] offset,
                            input logic signed [SAMPLE_W-1:0] sample,
                            input logic [AMOUNT_W-1:0] amount);
      int gap;
      // Every fifth stretch of fifty words goes out with no gaps at all.
      gap = (((words_sent / 50) % 5) == 2) ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.offset = offset;
      req_ch.sample = sample;
      req_ch.amount = amount;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      @(negedge clock);
   endtask

   // Draws one random command for a ring of the given length. Most offsets land in
   // a short window above the read pointer so that mixes pile up on the same entries
   // and reads find them; most advances are short hops as in a real overlap-add.
   task automatic send_random_word(input int ring_len);
      int pick;
      int win;
      logic [OFFSET_W-1:0] offset;
      logic signed [SAMPLE_W-1:0] sample;
      logic [AMOUNT_W-1:0] amount;
      cmd_type cmd;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_MIX;
      else if (pick < 50) cmd = CMD_PASTE;
      else if (pick < 75) cmd = CMD_READ;
      else cmd = CMD_ADVANCE;
      win = (ring_len < 64) ? ring_len - 1 : 63;
      offset = ($urandom_range(0, 99) < 80) ? OFFSET_W'($urandom_range(0, win))
                                            : OFFSET_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) sample = SAMPLE_MAX;
      else if (pick < 16) sample = SAMPLE_MIN;
      else if (pick < 24) sample = SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 7));
      else sample = SAMPLE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) amount = AMOUNT_W'($urandom_range(0, (ring_len < 16) ? ring_len : 16));
      else if (pick < 95) amount = AMOUNT_W'($urandom_range(0, ring_len));
      else amount = AMOUNT_W'($urandom);
      send_word(cmd, offset, sample, amount);
   endtask

   // Stops offering words and waits until every expected result word has come back.
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   // Writes the size register over an APB setup and access phase, with the block idle.
   task automatic write_size(input logic [SIZE_LOG2_W-1:0] value);
      wait_drained();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {REG_SIZE_LOG2, 2'b00};
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Result side: random ready gaps, a gap-free stretch now and then, and one long
   // hold-off that lets the queue fill and stalls the command side.
   initial begin
      int got;
      int gap;
      got = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (got == HOLD_AT) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = (((got / 70) % 4) == 1) ? 0 : int'($urandom_range(0, 11));
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got++;
         @(negedge clock);
      end
   end

   // Watchdog: too long without any word moving on either channel ends the run.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [SIZE_LOG2_W-1:0] size_steps [10];
      int lg;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_MIX;
      req_ch.offset = '0;
      req_ch.sample = '0;
      req_ch.amount = '0;
      words_sent = 0;
      // Sizes cover the range ends, values below and above the range, and a middle.
      size_steps = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd13, 4'd4, 4'd9, 4'd12};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset size of 4096 entries. The block sweeps its store
      // after reset; the first word simply waits for ready.
      send_word(CMD_PASTE, 12'd0, SAMPLE_MAX, 13'd0);
      send_word(CMD_MIX, 12'd0, 24'sd1, 13'd0);               // saturates high
      send_word(CMD_READ, 12'd0, SAMPLE_W'($urandom), 13'd0);
      send_word(CMD_PASTE, 12'd4095, SAMPLE_MIN, 13'd0);      // pending reaches 4096
      send_word(CMD_MIX, 12'd4095, -24'sd1, 13'd0);           // saturates low
      send_word(CMD_READ, 12'd4095, SAMPLE_W'($urandom), 13'd0);
      send_word(CMD_PASTE, 12'd100, 24'sh555555, 13'd0);
      send_word(CMD_MIX, 12'd100, 24'shAAAAAA, 13'd0);
      send_word(CMD_READ, 12'd100, 24'sd0, 13'd0);
      send_word(CMD_ADVANCE, 12'd0, SAMPLE_W'($urandom), 13'd0);
      send_word(CMD_ADVANCE, 12'd0, SAMPLE_W'($urandom), 13'd1);
      send_word(CMD_READ, 12'd4095, 24'sd0, 13'd0);            // entry zeroed by the hop
      send_word(CMD_READ, 12'd99, 24'sd0, 13'd0);
      send_word(CMD_MIX, 12'd7, SAMPLE_MAX, 13'd0);
      send_word(CMD_MIX, 12'd7, SAMPLE_MAX, 13'd0);
      send_word(CMD_MIX, 12'd7, SAMPLE_MIN, 13'd0);
      send_word(CMD_READ, 12'd7, 24'sd0, 13'd0);
      // Advance far past the ring: everything cleared, pointer wraps, count empties.
      send_word(CMD_ADVANCE, 12'hABC, 24'sd0, 13'h1FFF);
      send_word(CMD_READ, 12'd7, 24'sd0, 13'd0);
      send_word(CMD_PASTE, 12'd2, 24'sh123456, 13'd0);
      send_word(CMD_ADVANCE, 12'd0, 24'sd0, 13'h1000);       // exactly one ring
      send_word(CMD_READ, 12'd2, 24'sd0, 13'd0);

      // Random phases, each at a new size setting written while the block is idle.
      foreach (size_steps[i]) begin
         write_size(size_steps[i]);
         lg = int'(size_steps[i]);
         if (lg < 1) lg = 1;
         if (lg > SIZE_LOG2_HI) lg = SIZE_LOG2_HI;
         repeat (PHASE_WORDS) send_random_word(1 << lg);
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
